// ===== src/ttod_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttod_pkg: shared definitions for the tick time-of-day keeper
// Holds the tick rate, the derived conversion constants, the operation codes
// and the command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package ttod_pkg;

   // Tick rate of the system timer, in ticks per second.
   localparam int unsigned TICKS_PER_SEC = 1000;

   localparam int unsigned USEC_PER_SEC  = 1000000;
   localparam int unsigned USEC_PER_TICK = USEC_PER_SEC / TICKS_PER_SEC;

   // Field widths.
   localparam int TICK_W   = 32;
   localparam int SEC_W    = 32;
   localparam int USEC_W   = 20;
   localparam int DELTA_W  = 16;
   localparam int UPTIME_W = 52;

   // Remainder of a tick count divided by the tick rate.
   localparam int REM_W = $clog2(TICKS_PER_SEC + 1);

   localparam logic [USEC_W-1:0] USEC_MAX      = USEC_W'(USEC_PER_SEC - 1);
   localparam logic [USEC_W-1:0] USEC_SEC      = USEC_W'(USEC_PER_SEC);
   localparam logic [USEC_W-1:0] USEC_TICK     = USEC_W'(USEC_PER_TICK);
   localparam logic [TICK_W-1:0] TPS_TICK      = TICK_W'(TICKS_PER_SEC);
   localparam logic [REM_W-1:0]  TPS_REM       = REM_W'(TICKS_PER_SEC);

   // Reciprocal of the tick rate scaled by 2^32; the quotient estimate it
   // gives is low by at most one.
   localparam logic [63:0] TWO_POW_32 = 64'h0000_0001_0000_0000;
   localparam logic [32:0] RECIP      = 33'(TWO_POW_32 / 64'(TICKS_PER_SEC));

   // Operation codes carried in the request sideband.
   typedef enum logic {
      OP_ADVANCE = 1'b0,
      OP_SET     = 1'b1
   } op_type;

   // One strobe per datapath step.
   typedef struct packed {
      logic accept;     // take the request and move the tick counter
      logic div_mul;    // elapsed ticks times reciprocal
      logic quot_mul;   // quotient estimate times tick rate
      logic correct;    // remainder correction
      logic usec_mul;   // remainder times microseconds per tick
      logic time_add;   // form current times and update the base
      logic up_mul;     // uptime seconds times one million
      logic out_load;   // load the result register
   } cmd_type;

endpackage

// ===== src/ttod_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttod_ctrl: sequencing controller
// Steps one request at a time through the datapath operations and owns the
// request ready and the result valid flag.
// ----------------------------------------------------------------------------
module ttod_ctrl
   import ttod_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_DIV  = 8'b0000_0010,
      S_QUOT = 8'b0000_0100,
      S_CORR = 8'b0000_1000,
      S_USEC = 8'b0001_0000,
      S_ADD  = 8'b0010_0000,
      S_UPT  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and step strobes.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_mul = 1'b1;
            state_in    = S_QUOT;
         end
         S_QUOT: begin
            cmd.quot_mul = 1'b1;
            state_in     = S_CORR;
         end
         S_CORR: begin
            cmd.correct = 1'b1;
            state_in    = S_USEC;
         end
         S_USEC: begin
            cmd.usec_mul = 1'b1;
            state_in     = S_ADD;
         end
         S_ADD: begin
            cmd.time_add = 1'b1;
            state_in     = S_UPT;
         end
         S_UPT: begin
            cmd.up_mul = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // Wait until the result register is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid flag: set on load, cleared by a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // A taken request always starts the division step next.
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_DIV))
      else $error("request accepted without starting the conversion");

   // The result register is never overwritten while it still holds a result.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before its transfer");

   // Every accepted request reaches the output stage after its six steps.
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> ##7 (state_ff == S_DONE))
      else $error("conversion sequence did not reach the output stage");
`endif

endmodule

// ===== src/ttod_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttod_dp: tick counter, time base and conversion datapath
// Holds the tick counter and the base times, converts the ticks elapsed since
// the base into seconds and microseconds, and builds the result.
// ----------------------------------------------------------------------------
module ttod_dp
   import ttod_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  op_type              req_op,
   input  logic [DELTA_W-1:0]  req_ticks,
   input  logic [SEC_W-1:0]    req_utc_sec,
   input  logic [USEC_W-1:0]   req_utc_usec,
   output logic [TICK_W-1:0]   rsp_tick_now,
   output logic [SEC_W-1:0]    rsp_utc_sec_now,
   output logic [USEC_W-1:0]   rsp_utc_usec_now,
   output logic [UPTIME_W-1:0] rsp_uptime_usec
);

   typedef struct packed {
      logic [SEC_W-1:0]  sec;
      logic [USEC_W-1:0] usec;
   } tod_type;

   // Adds an elapsed time to a base time with the microsecond carry.
   function automatic tod_type add_time(tod_type base, logic [SEC_W-1:0] dsec,
                                        logic [USEC_W-1:0] dusec);
      logic [USEC_W:0] usum;
      tod_type         res;
      usum     = {1'b0, base.usec} + {1'b0, dusec};
      res.sec  = base.sec + dsec;
      res.usec = usum[USEC_W-1:0];
      if (usum >= {1'b0, USEC_SEC}) begin
         usum     = usum - {1'b0, USEC_SEC};
         res.usec = usum[USEC_W-1:0];
         res.sec  = res.sec + SEC_W'(1);
      end
      return res;
   endfunction

   // Architectural state.
   logic [TICK_W-1:0] tick_ff, base_tick_ff;
   tod_type           base_up_ff, base_utc_ff;

   // Request held for the duration of the conversion.
   op_type            op_ff;
   logic              flip_ff;
   tod_type           set_ff;

   // Conversion pipeline registers.
   logic [TICK_W-1:0]   delta_ff;
   logic [64:0]         prod_ff;
   logic [TICK_W-1:0]   quot_ff;
   logic [TICK_W-1:0]   qt_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [USEC_W-1:0]   dusec_ff;
   tod_type             now_utc_ff, now_up_ff;
   logic [UPTIME_W-1:0] up_prod_ff;

   // Result register.
   logic [TICK_W-1:0]   out_tick_ff;
   tod_type             out_utc_ff;
   logic [UPTIME_W-1:0] out_up_ff;

   logic [TICK_W-1:0] tick_sum;
   logic [USEC_W-1:0] usec_sat;
   logic [63:0]       qt_full;
   logic [TICK_W-1:0] rem_raw;
   logic [31:0]       dusec_full;
   tod_type           utc_cur, up_cur;

   assign tick_sum   = tick_ff + TICK_W'(req_ticks);
   assign usec_sat   = (req_utc_usec > USEC_MAX) ? USEC_MAX : req_utc_usec;
   assign qt_full    = 64'(prod_ff[63:32]) * 64'(TPS_TICK);
   assign rem_raw    = delta_ff - qt_ff;
   assign dusec_full = 32'(rem_ff) * 32'(USEC_TICK);
   assign utc_cur    = add_time(base_utc_ff, quot_ff, dusec_ff);
   assign up_cur     = add_time(base_up_ff, quot_ff, dusec_ff);

   // Tick counter and time base.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         base_tick_ff <= '0;
         base_up_ff   <= '0;
         base_utc_ff  <= '0;
      end else begin
         if (cmd.accept && (req_op == OP_ADVANCE)) begin
            tick_ff <= tick_sum;
         end
         if (cmd.time_add) begin
            if (op_ff == OP_SET) begin
               base_up_ff   <= up_cur;
               base_utc_ff  <= set_ff;
               base_tick_ff <= tick_ff;
            end else if (flip_ff) begin
               base_up_ff   <= up_cur;
               base_utc_ff  <= utc_cur;
               base_tick_ff <= tick_ff;
            end
         end
      end
   end

   // Request capture and the conversion steps.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req_op;
         flip_ff      <= (req_op == OP_ADVANCE) && (tick_sum[TICK_W-1] != tick_ff[TICK_W-1]);
         set_ff.sec   <= req_utc_sec;
         set_ff.usec  <= usec_sat;
      end
      if (cmd.div_mul) begin
         delta_ff <= tick_ff - base_tick_ff;
         prod_ff  <= 65'(tick_ff - base_tick_ff) * 65'(RECIP);
      end
      if (cmd.quot_mul) begin
         quot_ff <= prod_ff[63:32];
         qt_ff   <= qt_full[31:0];
      end
      if (cmd.correct) begin
         // The estimate is low by at most one quotient step.
         if (rem_raw >= TPS_TICK) begin
            quot_ff <= quot_ff + TICK_W'(1);
            rem_ff  <= REM_W'(rem_raw - TPS_TICK);
         end else begin
            rem_ff  <= REM_W'(rem_raw);
         end
      end
      if (cmd.usec_mul) begin
         dusec_ff <= dusec_full[USEC_W-1:0];
      end
      if (cmd.time_add) begin
         now_up_ff  <= up_cur;
         now_utc_ff <= (op_ff == OP_SET) ? set_ff : utc_cur;
      end
      if (cmd.up_mul) begin
         up_prod_ff <= UPTIME_W'(now_up_ff.sec) * UPTIME_W'(USEC_SEC);
      end
      if (cmd.out_load) begin
         out_tick_ff <= tick_ff;
         out_utc_ff  <= now_utc_ff;
         out_up_ff   <= up_prod_ff + UPTIME_W'(now_up_ff.usec);
      end
   end

   assign rsp_tick_now     = out_tick_ff;
   assign rsp_utc_sec_now  = out_utc_ff.sec;
   assign rsp_utc_usec_now = out_utc_ff.usec;
   assign rsp_uptime_usec  = out_up_ff;

`ifndef SYNTH
   // The corrected remainder is always below the tick rate.
   assert property (@(posedge clock) disable iff (reset)
      cmd.correct |=> (rem_ff < TPS_REM))
      else $error("tick remainder not below the tick rate");

   // Current times always hold a microsecond value within one second.
   assert property (@(posedge clock) disable iff (reset)
      cmd.time_add |=> ((now_up_ff.usec <= USEC_MAX) && (now_utc_ff.usec <= USEC_MAX)))
      else $error("microseconds out of range after the time add");
`endif

endmodule

// ===== src/tick_time_of_day_keeper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_time_of_day_keeper: tick counter with uptime and UTC time of day
//
// Channel  Direction  Payload
// req      in         tdata: ticks, utc_sec, utc_usec; tuser: op
// rsp      out        tdata: tick_now, utc_sec_now, utc_usec_now, uptime_usec
//
// One request is handled at a time: a transfer on req starts six sequenced
// steps (the reciprocal multiply, the quotient times the tick rate, a remainder
// correction, the microsecond multiply, the time add and the uptime multiply),
// and the result is then loaded in a done state, which waits while the previous
// result is unread. req is ready again in the cycle the result appears.
// The result waits in its own register, so a stalled rsp holds the finished
// item while the next request is taken; a second result waits for the first.
// Reset is synchronous and clears the tick counter and the whole time base.
// ----------------------------------------------------------------------------
module tick_time_of_day_keeper
   import ttod_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // ticks[15:0], utc_sec[47:16], utc_usec[67:48], zero
   input  logic         req_tuser,   // op[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tick_now[31:0], utc_sec_now[63:32], utc_usec_now[83:64], uptime_usec[135:84]
   output logic [135:0] rsp_tdata
);

   cmd_type             cmd;
   op_type              req_op;
   logic [TICK_W-1:0]   tick_now;
   logic [SEC_W-1:0]    utc_sec_now;
   logic [USEC_W-1:0]   utc_usec_now;
   logic [UPTIME_W-1:0] uptime_usec;

   assign req_op = op_type'(req_tuser);

   // Step sequencing and handshakes.
   ttod_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Counter, base and conversion arithmetic.
   ttod_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_op           (req_op),
      .req_ticks        (req_tdata[15:0]),
      .req_utc_sec      (req_tdata[47:16]),
      .req_utc_usec     (req_tdata[67:48]),
      .rsp_tick_now     (tick_now),
      .rsp_utc_sec_now  (utc_sec_now),
      .rsp_utc_usec_now (utc_usec_now),
      .rsp_uptime_usec  (uptime_usec)
   );

   assign rsp_tdata = {uptime_usec, utc_usec_now, utc_sec_now, tick_now};

endmodule

// ===== tb/sv/tick_time_of_day_keeper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_time_of_day_keeper_tb: self-checking bench for the tick time keeper
// Each accepted request runs through a local copy of the tick counter and
// time base, and the expected report is queued. Every report transfer is
// checked field by field against the oldest queued one. Directed cases cover
// zero and maximum ticks, ignored fields, microsecond saturation and UTC
// second wrap. Random traffic with idle cycles on both channels follows,
// once after a set near the top of the UTC range and once after a set just
// below a UTC second wrap.
// ----------------------------------------------------------------------------
module tick_time_of_day_keeper_tb
   import ttod_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int          IDLE_PCT    = 27;
   localparam int          SET_PCT     = 20;

   // One request and one report, as the channels carry them.
   typedef struct packed {
      op_type      op;
      logic [15:0] ticks;
      logic [31:0] utc_sec;
      logic [19:0] utc_usec;
   } tod_cmd_type;

   typedef struct packed {
      logic [51:0] uptime_usec;
      logic [19:0] utc_usec_now;
      logic [31:0] utc_sec_now;
      logic [31:0] tick_now;
   } tod_report_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata  = '0;   // ticks[15:0], utc_sec[47:16], utc_usec[67:48], zero
   logic         req_tuser  = 1'b0; // op[0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // tick_now[31:0], utc_sec_now[63:32], utc_usec_now[83:64], uptime_usec[135:84]
   logic [135:0] rsp_tdata;

   // When set, neither side inserts idle cycles.
   logic         steady = 1'b0;
   int unsigned  cycle_count = 0;
   int unsigned  mismatch_count = 0;

   tod_report_type report_q[$];

   // Local copy of the counter and the time base.
   logic [31:0]  tod_tick;
   logic [31:0]  tod_base_tick;
   logic [31:0]  tod_up_sec;
   logic [19:0]  tod_up_usec;
   logic [31:0]  tod_utc_sec;
   logic [19:0]  tod_utc_usec;

   tick_time_of_day_keeper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[tick_time_of_day_keeper] ERROR");
         $finish;
      end
   end

   // Adds elapsed ticks to a time held as seconds and microseconds.
   function automatic void add_elapsed(input logic [31:0] elapsed,
                                       input logic [31:0] sec,
                                       input logic [19:0] usec,
                                       output logic [31:0] sec_out,
                                       output logic [19:0] usec_out);
      logic [31:0] whole_sec;
      logic [31:0] frac_usec;
      logic [31:0] sum_sec;
      logic [31:0] sum_usec;
      whole_sec = elapsed / TICKS_PER_SEC;
      frac_usec = (elapsed % TICKS_PER_SEC) * USEC_PER_TICK;
      sum_sec   = sec + whole_sec;
      sum_usec  = {12'b0, usec} + frac_usec;
      if (sum_usec >= USEC_PER_SEC) begin
         sum_usec = sum_usec - USEC_PER_SEC;
         sum_sec  = sum_sec + 1;
      end
      sec_out  = sum_sec;
      usec_out = sum_usec[19:0];
   endfunction

   // Applies one request to the local state and returns the report it yields.
   function automatic tod_report_type predict_report(input tod_cmd_type c);
      tod_report_type r;
      logic [31:0]    prev_tick;
      logic [31:0]    elapsed;
      logic [19:0]    load_usec;
      logic [31:0]    up_sec;
      logic [19:0]    up_usec;
      load_usec = (c.utc_usec > USEC_MAX) ? USEC_MAX : c.utc_usec;
      if (c.op == OP_ADVANCE) begin
         if (c.ticks != 16'd0) begin
            prev_tick = tod_tick;
            tod_tick  = tod_tick + {16'b0, c.ticks};
            // A top-bit change folds the elapsed ticks into the base.
            if (prev_tick[31] != tod_tick[31]) begin
               elapsed = tod_tick - tod_base_tick;
               add_elapsed(elapsed, tod_up_sec, tod_up_usec, tod_up_sec, tod_up_usec);
               add_elapsed(elapsed, tod_utc_sec, tod_utc_usec, tod_utc_sec, tod_utc_usec);
               tod_base_tick = tod_tick;
            end
         end
      end else begin
         elapsed = tod_tick - tod_base_tick;
         add_elapsed(elapsed, tod_up_sec, tod_up_usec, tod_up_sec, tod_up_usec);
         tod_utc_sec   = c.utc_sec;
         tod_utc_usec  = load_usec;
         tod_base_tick = tod_tick;
      end
      elapsed = tod_tick - tod_base_tick;
      add_elapsed(elapsed, tod_utc_sec, tod_utc_usec, r.utc_sec_now, r.utc_usec_now);
      add_elapsed(elapsed, tod_up_sec, tod_up_usec, up_sec, up_usec);
      r.tick_now    = tod_tick;
      r.uptime_usec = 52'(64'(up_sec) * 64'(USEC_PER_SEC) + 64'(up_usec));
      return r;
   endfunction

   function automatic tod_cmd_type make_cmd(input op_type op, input logic [15:0] ticks,
                                            input logic [31:0] sec,
                                            input logic [19:0] usec);
      tod_cmd_type c;
      c.op       = op;
      c.ticks    = ticks;
      c.utc_sec  = sec;
      c.utc_usec = usec;
      return c;
   endfunction

   // Random request; fields that the operation ignores are random as well.
   function automatic tod_cmd_type random_cmd(input int set_pct);
      tod_cmd_type c;
      int unsigned pick;
      c.op = ($urandom_range(99) < set_pct) ? OP_SET : OP_ADVANCE;
      pick = $urandom_range(99);
      if (pick < 10)      c.ticks = 16'd0;
      else if (pick < 20) c.ticks = 16'hFFFF;
      else if (pick < 50) c.ticks = 16'($urandom_range(1, 1000));
      else                c.ticks = 16'($urandom_range(0, 65535));
      pick = $urandom_range(99);
      if (pick < 15)      c.utc_sec = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      else if (pick < 30) c.utc_sec = $urandom_range(0, 100);
      else                c.utc_sec = $urandom;
      if ($urandom_range(99) < 15) c.utc_usec = 20'($urandom_range(1000000, 1048575));
      else                         c.utc_usec = 20'($urandom_range(0, 999999));
      return c;
   endfunction

   // Sends one request and queues its report once the transfer happens.
   task automatic send_cmd(input tod_cmd_type c);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, c.utc_usec, c.utc_sec, c.ticks};
      req_tuser  <= c.op;
      do @(posedge clock); while (!req_tready);
      report_q.push_back(predict_report(c));
   endtask

   // Holds the request side until every queued report has arrived.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [51:0] expected,
                              input logic [51:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatch_count++;
      end
   endtask

   // Report side: check each transfer, then choose the next ready value.
   always @(posedge clock) begin
      tod_report_type got;
      tod_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (report_q.size() == 0) begin
            $error("report transfer with no request outstanding");
            mismatch_count++;
         end else begin
            want = report_q.pop_front();
            check_field("tick_now", 52'(want.tick_now), 52'(got.tick_now));
            check_field("utc_sec_now", 52'(want.utc_sec_now), 52'(got.utc_sec_now));
            check_field("utc_usec_now", 52'(want.utc_usec_now), 52'(got.utc_usec_now));
            check_field("uptime_usec", want.uptime_usec, got.uptime_usec);
         end
      end
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Extremes of each field, ignored fields, saturation and UTC wrap.
   task automatic test_directed();
      send_cmd(make_cmd(OP_ADVANCE, 16'd0, 32'hFFFF_FFFF, 20'hFFFFF));
      send_cmd(make_cmd(OP_ADVANCE, 16'd1, 32'd0, 20'd0));
      send_cmd(make_cmd(OP_ADVANCE, 16'd999, 32'hFFFF_FFFF, 20'd999999));
      send_cmd(make_cmd(OP_ADVANCE, 16'hFFFF, 32'h5A5A_A5A5, 20'h5A5A5));
      send_cmd(make_cmd(OP_SET, 16'hFFFF, 32'd0, 20'd0));
      send_cmd(make_cmd(OP_ADVANCE, 16'd500, 32'd0, 20'd0));
      send_cmd(make_cmd(OP_SET, 16'd0, 32'hFFFF_FFFF, 20'd999999));
      // One more tick carries into the second and wraps UTC seconds.
      send_cmd(make_cmd(OP_ADVANCE, 16'd1, 32'd0, 20'd0));
      send_cmd(make_cmd(OP_ADVANCE, 16'd0, 32'd0, 20'd0));
      send_cmd(make_cmd(OP_SET, 16'd7, 32'd1, 20'd1000000));
      send_cmd(make_cmd(OP_SET, 16'h8000, 32'd2, 20'hFFFFF));
      send_cmd(make_cmd(OP_SET, 16'd0, 32'd12345678, 20'd999998));
      send_cmd(make_cmd(OP_ADVANCE, 16'hFFFF, 32'hAAAA_5555, 20'hAAAAA));
      send_cmd(make_cmd(OP_SET, 16'd1, 32'h8000_0000, 20'd1));
      send_cmd(make_cmd(OP_ADVANCE, 16'd1000, 32'd0, 20'd0));
      drain_reports();
   endtask

   // Random traffic with a stretch of steady transfers and one full pause.
   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         steady = (i >= count / 3) && (i < count / 3 + 40);
         if (i == count / 2) drain_reports();
         send_cmd(random_cmd(SET_PCT));
      end
      steady = 1'b0;
   endtask

   // Random traffic after a set high in the UTC range.
   task automatic test_random_after_set();
      send_cmd(make_cmd(OP_SET, 16'd0, 32'hFFF0_0000, 20'd123456));
      test_random_mix(220);
   endtask

   // Random traffic after a set just below a UTC second wrap.
   task automatic test_random_near_wrap();
      send_cmd(make_cmd(OP_SET, 16'd0, 32'hFFFF_FFF0, 20'd999000));
      test_random_mix(230);
   endtask

   initial begin
      tod_tick      = '0;
      tod_base_tick = '0;
      tod_up_sec    = '0;
      tod_up_usec   = '0;
      tod_utc_sec   = '0;
      tod_utc_usec  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_after_set();
      test_random_near_wrap();
      drain_reports();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[tick_time_of_day_keeper] OK");
      end else begin
         $display("[tick_time_of_day_keeper] ERROR");
      end
      $finish;
   end

endmodule
